// ----- design/rwl_pkg.sv -----
// Shared types and codes for the named reader-writer lock table.
// No dependencies; used by rwl_decide and named_rw_lock_table.
package rwl_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_ACQ_RD = 2'd0;
  localparam mode_t MODE_ACQ_WR = 2'd1;
  localparam mode_t MODE_REL_RD = 2'd2;
  localparam mode_t MODE_REL_WR = 2'd3;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_WAIT = 2'd1;
  localparam status_t ST_FAIL = 2'd2;

  // Outcome of one request, handed from the decision logic to the controller.
  typedef struct packed {
    status_t status;
    logic    wake;
    logic    mem_we;
    logic    set_valid;
    logic    clr_valid;
    logic    report;
  } rwl_ctrl_t;

endpackage

// ----- design/rwl_entry_mem.sv -----
// Entry store of the lock table: key, reader count and writer flag per slot.
// Synchronous memory, one write port, one read port with registered data.
module rwl_entry_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 73
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rwl_decide.sv -----
// Grant and release decision for one lock request.
// Depends on rwl_pkg for modes, status codes and the control struct.
module rwl_decide
  import rwl_pkg::*;
#(
  parameter int READER_BITS = 8
) (
  input  mode_t                  mode,
  input  logic                   found,
  input  logic                   free_found,
  input  logic [READER_BITS-1:0] hit_readers,
  input  logic                   hit_writer,
  output rwl_ctrl_t              ctrl,
  output logic [READER_BITS-1:0] new_readers,
  output logic                   new_writer
);

  logic [READER_BITS-1:0] base_r;
  logic                   base_w;
  logic                   grant;

  // A newly allocated entry starts with no readers and no writer.
  assign base_r = found ? hit_readers : '0;
  assign base_w = found ? hit_writer : 1'b0;

  always_comb begin
    ctrl        = '0;
    ctrl.status = ST_FAIL;
    new_readers = base_r;
    new_writer  = base_w;
    grant       = 1'b0;
    case (mode)
      MODE_ACQ_RD, MODE_ACQ_WR: begin
        if (found || free_found) begin
          if (mode == MODE_ACQ_RD) begin
            grant = !base_w && (base_r != '1);
            if (grant) begin
              new_readers = base_r + READER_BITS'(1);
            end
          end else begin
            grant = !base_w && (base_r == '0);
            if (grant) begin
              new_writer = 1'b1;
            end
          end
          ctrl.status    = grant ? ST_DONE : ST_WAIT;
          ctrl.mem_we    = grant || !found;
          ctrl.set_valid = !found;
          ctrl.report    = 1'b1;
        end
      end
      MODE_REL_RD: begin
        if (found && (base_r != '0)) begin
          new_readers    = base_r - READER_BITS'(1);
          ctrl.status    = ST_DONE;
          ctrl.wake      = 1'b1;
          ctrl.mem_we    = 1'b1;
          ctrl.clr_valid = (new_readers == '0) && !base_w;
          ctrl.report    = 1'b1;
        end
      end
      MODE_REL_WR: begin
        if (found && base_w) begin
          new_writer     = 1'b0;
          ctrl.status    = ST_DONE;
          ctrl.wake      = 1'b1;
          ctrl.mem_we    = 1'b1;
          ctrl.clr_valid = (base_r == '0);
          ctrl.report    = 1'b1;
        end
      end
      default: begin
        ctrl.status = ST_FAIL;
      end
    endcase
  end

endmodule

// ----- design/named_rw_lock_table.sv -----
// Top level of the named reader-writer lock table.
// Depends on rwl_pkg, rwl_entry_mem and rwl_decide.
//
// Usage: a request word (mode, lock_key) is taken at a rising edge where
// start is high and busy is low. The block then walks every slot of the
// entry memory, one read per cycle, comparing stored keys against the
// request and noting the lowest free slot. A FINISH state then completes
// the last compare, and a DECIDE state decides and writes the entry back.
// The result word (status, wake, slot, readers_now, writer_now) shows for
// exactly one cycle with done high, registered out of the DECIDE state;
// busy drops in that same cycle, so a new request can be taken at the
// edge that ends it. Requests are handled one at a time: no new request
// is taken before the last one has been answered, as the scan holds the
// single read port of the memory.
// The receiver cannot stall; a result is gone after its one cycle.
// Reset clears all valid marks, so every slot is free, and returns the
// controller to idle. The memory itself needs no clearing: an entry is
// only used while its valid mark is set, and it is always written
// when the slot is allocated.
module named_rw_lock_table
  import rwl_pkg::*;
#(
  parameter int LOCK_SLOTS  = 32,
  parameter int KEY_BITS    = 64,
  parameter int READER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] lock_key,
  output logic        done,
  output logic [1:0]  status,
  output logic        wake,
  output logic [4:0]  slot,
  output logic [7:0]  readers_now,
  output logic        writer_now
);

  localparam int SLOT_W  = $clog2(LOCK_SLOTS);
  localparam int ENTRY_W = KEY_BITS + READER_BITS + 1;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH, DECIDE} state_t;

  state_t                 state;
  mode_t                  req_mode;
  logic [KEY_BITS-1:0]    req_key;
  logic [LOCK_SLOTS-1:0]  valid;
  logic [SLOT_W-1:0]      scan_addr;
  logic [SLOT_W-1:0]      cmp_idx;
  logic                   cmp_vld;
  logic                   found;
  logic [SLOT_W-1:0]      hit_idx;
  logic [READER_BITS-1:0] hit_readers;
  logic                   hit_writer;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;

  logic [ENTRY_W-1:0]     rd_data;
  logic [KEY_BITS-1:0]    rd_key;
  logic [READER_BITS-1:0] rd_readers;
  logic                   rd_writer;
  logic                   key_match;

  rwl_ctrl_t              ctrl;
  logic [READER_BITS-1:0] new_readers;
  logic                   new_writer;
  logic [SLOT_W-1:0]      use_idx;
  logic                   mem_we;
  logic [8:0]             slot_wide;
  logic [15:0]            readers_wide;

  assign busy = (state != IDLE);

  assign rd_key     = rd_data[ENTRY_W-1 -: KEY_BITS];
  assign rd_readers = rd_data[READER_BITS:1];
  assign rd_writer  = rd_data[0];
  assign key_match  = valid[cmp_idx] && (rd_key == req_key);

  assign use_idx      = found ? hit_idx : free_idx;
  assign mem_we       = (state == DECIDE) && ctrl.mem_we;
  assign slot_wide    = 9'(use_idx);
  assign readers_wide = 16'(new_readers);

  rwl_entry_mem #(
    .DEPTH(LOCK_SLOTS),
    .WIDTH(ENTRY_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(use_idx),
    .wdata({req_key, new_readers, new_writer}),
    .re   (state == SCAN),
    .raddr(scan_addr),
    .rdata(rd_data)
  );

  rwl_decide #(
    .READER_BITS(READER_BITS)
  ) u_decide (
    .mode       (req_mode),
    .found      (found),
    .free_found (free_found),
    .hit_readers(hit_readers),
    .hit_writer (hit_writer),
    .ctrl       (ctrl),
    .new_readers(new_readers),
    .new_writer (new_writer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      valid      <= '0;
      done       <= 1'b0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      scan_addr  <= '0;
    end else begin
      done <= 1'b0;
      // Compare stage: checks the slot whose read was issued in the previous cycle.
      if (cmp_vld) begin
        if (!found && key_match) begin
          found       <= 1'b1;
          hit_idx     <= cmp_idx;
          hit_readers <= rd_readers;
          hit_writer  <= rd_writer;
        end
        if (!free_found && !valid[cmp_idx]) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
      case (state)
        IDLE: begin
          if (start) begin
            req_mode   <= mode;
            req_key    <= lock_key[KEY_BITS-1:0];
            scan_addr  <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          cmp_vld <= 1'b1;
          cmp_idx <= scan_addr;
          if (scan_addr == SLOT_W'(LOCK_SLOTS - 1)) begin
            state <= FINISH;
          end else begin
            scan_addr <= scan_addr + SLOT_W'(1);
          end
        end
        FINISH: begin
          cmp_vld <= 1'b0;
          state   <= DECIDE;
        end
        DECIDE: begin
          if (ctrl.set_valid) begin
            valid[use_idx] <= 1'b1;
          end
          if (ctrl.clr_valid) begin
            valid[use_idx] <= 1'b0;
          end
          done        <= 1'b1;
          status      <= ctrl.status;
          wake        <= ctrl.wake;
          slot        <= ctrl.report ? slot_wide[4:0] : 5'd0;
          readers_now <= ctrl.report ? readers_wide[7:0] : 8'd0;
          writer_now  <= ctrl.report ? new_writer : 1'b0;
          state       <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // One result per request, and requests are handled one at a time.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not make the table busy");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FAIL) |-> !wake && (slot == 5'd0) &&
      (readers_now == 8'd0) && !writer_now)
    else $error("failed request reported entry data");

  a_wake_done: assert property (@(posedge clk) disable iff (rst)
    done && wake |-> (status == ST_DONE))
    else $error("wake raised on a request that did not complete");

endmodule
